@@ rtl/core/fifo_queue_with_contains_top_defines.svh @@
// assertion macros for the checker file
`ifndef FIFO_QUEUE_WITH_CONTAINS_TOP_DEFINES_SVH
`define FIFO_QUEUE_WITH_CONTAINS_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FQWC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define FQWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fqwc_pkg.sv @@
`timescale 1ns / 1ps
package fqwc_pkg;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  // request codes
  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_DEQ    = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch_req;
    logic exec_op;
    logic scan_start;
    logic scan_read;
    logic finish_search;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_nonempty;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/fqwc_ctrl.sv @@
`timescale 1ns / 1ps
module fqwc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fqwc_pkg::sts_t sts,
  output fqwc_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SETTLE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.search_nonempty) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (sts.out_free) begin
          cmd.exec_op = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_read = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SETTLE;
        end
      end
      // last read word is compared here
      S_SETTLE: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish_search = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/fqwc_dp.sv @@
`timescale 1ns / 1ps
module fqwc_dp #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  fqwc_pkg::cmd_t                     cmd,
  output fqwc_pkg::sts_t                     sts,
  input  logic [1:0]                         req_type,
  input  logic signed [fqwc_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [fqwc_pkg::COUNT_W-1:0]       count,
  output logic [1:0]                         status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [fqwc_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [1:0]                   req;
  logic [fqwc_pkg::VALUE_W-1:0] key;
  logic [PTR_W-1:0]             rd_ptr;
  logic [PTR_W-1:0]             wr_ptr;
  logic [CNT_W-1:0]             cnt;
  logic [PTR_W-1:0]             scan_addr;
  logic [CNT_W-1:0]             remaining;
  logic [fqwc_pkg::VALUE_W-1:0] rd_data;
  logic                         rd_valid;
  logic                         hit;

  logic             is_full;
  logic             is_empty;
  logic             do_enq;
  logic             do_deq;
  logic [CNT_W-1:0] cnt_next;
  logic [1:0]       status_next;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  assign is_full  = (cnt == CNT_W'(DEPTH));
  assign is_empty = (cnt == '0);
  assign do_enq   = cmd.exec_op && (req == fqwc_pkg::REQ_ENQ) && !is_full;
  assign do_deq   = cmd.exec_op && (req == fqwc_pkg::REQ_DEQ) && !is_empty;

  always_comb begin
    cnt_next    = cnt;
    status_next = fqwc_pkg::ST_DONE;
    case (req)
      fqwc_pkg::REQ_ENQ: begin
        if (is_full) begin
          status_next = fqwc_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      fqwc_pkg::REQ_DEQ: begin
        if (is_empty) begin
          status_next = fqwc_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      default: begin
        cnt_next    = cnt;
        status_next = fqwc_pkg::ST_DONE;
      end
    endcase
  end

  assign sts.search_nonempty = (req == fqwc_pkg::REQ_SEARCH) && !is_empty;
  assign sts.scan_last       = (remaining == CNT_W'(1));
  assign sts.out_free        = !out_valid || out_ready;

  // entry store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wr_ptr] <= key;
    end
    if (cmd.scan_read) begin
      rd_data <= mem[scan_addr];
    end
  end

  // request and scan registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req <= req_type;
      key <= value;
    end
    if (cmd.scan_start) begin
      scan_addr <= rd_ptr;
      remaining <= cnt;
    end else if (cmd.scan_read) begin
      scan_addr <= ring_next(scan_addr);
      remaining <= remaining - CNT_W'(1);
    end
    if (cmd.scan_start) begin
      hit <= 1'b0;
    end else if (rd_valid && (rd_data == key)) begin
      hit <= 1'b1;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_read;
      if (do_enq) begin
        wr_ptr <= ring_next(wr_ptr);
      end
      if (do_deq) begin
        rd_ptr <= ring_next(rd_ptr);
      end
      if (cmd.exec_op) begin
        cnt <= cnt_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec_op || cmd.finish_search) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_op) begin
      found  <= 1'b0;
      count  <= fqwc_pkg::COUNT_W'(cnt_next);
      status <= status_next;
    end else if (cmd.finish_search) begin
      found  <= hit;
      count  <= fqwc_pkg::COUNT_W'(cnt);
      status <= fqwc_pkg::ST_DONE;
    end
  end

endmodule

@@ rtl/core/fifo_queue_with_contains_top.sv @@
`timescale 1ns / 1ps
// first-in first-out queue of 32-bit signed values in a ring of DEPTH entries, with a
// membership search. each request on the input channel (req_type 0 enqueue, 1 dequeue,
// 2 search for value) gives exactly one result: found (search hit), count (entries held
// after the request, kept to its low 5 bits) and status (0 done, 1 enqueue rejected as
// full, 2 dequeue on an empty queue ignored). request code 3 changes nothing and reports
// the current count. requests are handled one at a time: an enqueue, dequeue, unused code
// or search of an empty queue is executed at dispatch once the output register is free,
// and a search reads the held entries one per cycle through the single registered
// read port of the entry memory. a finished result sits in an output register, so
// the next request is taken while it waits for its transfer.
// no clearing pass after reset: only entries that have been written are ever compared.
module fifo_queue_with_contains_top #(
  parameter int DEPTH = 16  // 2 to 1024 entries
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         req_type,
  input  logic signed [fqwc_pkg::VALUE_W-1:0] value,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               found,
  output logic [fqwc_pkg::COUNT_W-1:0]       count,
  output logic [1:0]                         status
);

  // command and status links between sequencer and datapath
  fqwc_pkg::cmd_t cmd;
  fqwc_pkg::sts_t sts;

  // sequencer: accepts a request, dispatches it, steps the search scan
  fqwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: entry ring, pointers, count, comparator and result register
  fqwc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .count     (count),
    .status    (status)
  );

endmodule

@@ rtl/core/fqwc_checker.sv @@
`timescale 1ns / 1ps
`include "fifo_queue_with_contains_top_defines.svh"
module fqwc_checker #(
  parameter int DEPTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         found,
  input logic [fqwc_pkg::COUNT_W-1:0] count,
  input logic [1:0]                   status
);

  localparam logic [fqwc_pkg::COUNT_W-1:0] FULL_COUNT = fqwc_pkg::COUNT_W'(DEPTH);

  // one request in flight at a time
  `FQWC_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "request taken while busy")

  // a result that is not taken stays offered
  `FQWC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")

  // rejected enqueue only when the ring is full
  `FQWC_ASSERT_NOW(a_full_count, clk, rst, out_valid && (status == fqwc_pkg::ST_FULL), count == FULL_COUNT, "full reject with wrong count")

  // ignored dequeue reports an empty queue and no hit
  `FQWC_ASSERT_NOW(a_empty_count, clk, rst, out_valid && (status == fqwc_pkg::ST_EMPTY), (count == '0) && !found, "empty dequeue with wrong result")

  // a hit comes only from a completed search
  `FQWC_ASSERT_NOW(a_found_done, clk, rst, out_valid && found, (status == fqwc_pkg::ST_DONE) && (count != '0 || DEPTH > 31), "hit with bad status or count")

endmodule

bind fifo_queue_with_contains_top fqwc_checker #(
  .DEPTH (DEPTH)
) u_fqwc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .found     (found),
  .count     (count),
  .status    (status)
);
